>>> sv/max_heap_priority_queue_macros.svh
// assertion macros for the checker of the max-heap priority queue
// no dependencies; take in with `include before use
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// property checked outside reset
`define MHPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked during reset as well
`define MHPQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> sv/mhpq_pkg.sv
// shared types, constants and node helpers for the max-heap priority queue
// no dependencies; used by the cell, the top level and the checker
package mhpq_pkg;

  localparam int CAPACITY    = 64;
  localparam int LEVELS      = $clog2(CAPACITY + 1);
  localparam int NODE_W      = LEVELS;
  localparam int IDX_W       = LEVELS - 1;
  localparam int LVL_W       = $clog2(LEVELS);
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 7;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_REMOVE = 1'b1;

  typedef logic signed [DATA_W-1:0] val_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_UP,
    K_DOWN,
    K_FETCH
  } tok_kind_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RD,
    C_CMP
  } cell_state_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_FETCH,
    T_BUSY,
    T_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic             valid;
    tok_kind_e        kind;
    val_t             value;
    logic [IDX_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    val_t             data;
  } wr_t;

  function automatic logic [LVL_W-1:0] node_level(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] pos;
    logic [LVL_W-1:0]  lvl;
    pos = node + NODE_W'(1);
    lvl = '0;
    for (int k = 0; k < NODE_W; k++) begin
      if (pos[k]) begin
        lvl = LVL_W'(k);
      end
    end
    return lvl;
  endfunction

  function automatic logic [IDX_W-1:0] node_index(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] pos;
    logic [LVL_W-1:0]  lvl;
    pos = node + NODE_W'(1);
    lvl = node_level(node);
    pos = pos & ~(NODE_W'(1) << lvl);
    return IDX_W'(pos);
  endfunction

endpackage

>>> sv/max_heap_priority_queue.sv
// an insert into a non-empty heap sifts its value up from the parent of the new node, a
// removal fetches the last entry and sifts it down from the root; one transaction is in flight
// at a time: a new one is taken only after the last result is loaded into the output register,
// so an output stall also holds off the input; in each level cell a read precedes a compare
// reset: asynchronous, empties the heap at once; memory contents are not cleared
// uses mhpq_pkg, mhpq_cell and mhpq_ram
module max_heap_priority_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] removed_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         entry_count_o,
  output logic signed [31:0] top_value_o,
  output logic               top_valid_o
);

  localparam int LEVELS = mhpq_pkg::LEVELS;

  mhpq_pkg::ctrl_state_e            state_q, state_d;
  logic [mhpq_pkg::NODE_W-1:0]      fill_q, fill_d;
  mhpq_pkg::val_t                   removed_q, removed_d;
  mhpq_pkg::status_e                status_q, status_d;
  mhpq_pkg::val_t                   top_q;

  logic                             out_valid_q;
  mhpq_pkg::val_t                   out_removed_q;
  mhpq_pkg::status_e                out_status_q;
  logic [mhpq_pkg::COUNT_OUT_W-1:0] out_count_q;
  mhpq_pkg::val_t                   out_top_q;
  logic                             out_top_valid_q;
  logic                             out_load;

  mhpq_pkg::tok_t                   start_tok;
  logic [mhpq_pkg::LVL_W-1:0]       start_lvl;
  mhpq_pkg::wr_t                    direct_wr;
  logic [mhpq_pkg::NODE_W-1:0]      last_node;

  mhpq_pkg::tok_t                   tok_in     [LEVELS];
  mhpq_pkg::tok_t                   tok_up     [LEVELS];
  mhpq_pkg::tok_t                   tok_dn     [LEVELS];
  mhpq_pkg::tok_t                   up_into    [LEVELS];
  mhpq_pkg::tok_t                   dn_into    [LEVELS];
  mhpq_pkg::wr_t                    wr_self    [LEVELS];
  mhpq_pkg::wr_t                    wr_above   [LEVELS];
  mhpq_pkg::wr_t                    wr_below   [LEVELS];
  mhpq_pkg::wr_t                    wr_up_into [LEVELS];
  mhpq_pkg::wr_t                    wr_dn_into [LEVELS];
  mhpq_pkg::wr_t                    direct_into[LEVELS];
  mhpq_pkg::wr_t                    wr_lvl     [LEVELS];
  logic [LEVELS-1:0]                done_vec;
  logic [LEVELS-1:0]                fetch_vec;
  mhpq_pkg::val_t                   fetch_data [LEVELS];
  logic [mhpq_pkg::IDX_W-1:0]       rd_idx_a   [LEVELS];
  logic [mhpq_pkg::IDX_W-1:0]       rd_idx_b   [LEVELS];
  mhpq_pkg::val_t                   rd_data_a  [LEVELS];
  mhpq_pkg::val_t                   rd_data_b  [LEVELS];

  logic                             done_any;
  logic                             fetch_any;
  mhpq_pkg::val_t                   fetch_val;

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    localparam int SPAN      = 1 << l;
    localparam int REMAIN    = mhpq_pkg::CAPACITY - SPAN + 1;
    localparam int LVL_DEPTH = (SPAN < REMAIN) ? SPAN : REMAIN;
    localparam int LAW       = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

    if (l > 0) begin : g_has_above
      assign dn_into[l]     = tok_dn[l-1];
      assign wr_dn_into[l]  = wr_below[l-1];
      assign direct_into[l] = '0;
    end else begin : g_root
      assign dn_into[l]     = '0;
      assign wr_dn_into[l]  = '0;
      assign direct_into[l] = direct_wr;
    end

    if (l < LEVELS - 1) begin : g_has_below
      assign up_into[l]    = tok_up[l+1];
      assign wr_up_into[l] = wr_above[l+1];
    end else begin : g_leaf
      assign up_into[l]    = '0;
      assign wr_up_into[l] = '0;
    end

    assign tok_in[l] = (start_tok.valid && start_lvl == mhpq_pkg::LVL_W'(l)) ? start_tok :
                       dn_into[l].valid ? dn_into[l] :
                       up_into[l].valid ? up_into[l] : '0;

    assign wr_lvl[l] = direct_into[l].en ? direct_into[l] :
                       wr_dn_into[l].en  ? wr_dn_into[l]  :
                       wr_up_into[l].en  ? wr_up_into[l]  : wr_self[l];

    mhpq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .level_base_i  (mhpq_pkg::NODE_W'(SPAN - 1)),
      .first_i       (l == 0),
      .last_i        (l == LEVELS - 1),
      .fill_i        (fill_q),
      .tok_i         (tok_in[l]),
      .tok_up_o      (tok_up[l]),
      .tok_dn_o      (tok_dn[l]),
      .wr_self_o     (wr_self[l]),
      .wr_above_o    (wr_above[l]),
      .wr_below_o    (wr_below[l]),
      .done_o        (done_vec[l]),
      .fetch_valid_o (fetch_vec[l]),
      .fetch_data_o  (fetch_data[l]),
      .rd_idx_a_o    (rd_idx_a[l]),
      .rd_idx_b_o    (rd_idx_b[l]),
      .rd_data_a_i   (rd_data_a[l]),
      .rd_data_b_i   (rd_data_b[l])
    );

    mhpq_ram #(
      .WIDTH (mhpq_pkg::DATA_W),
      .DEPTH (LVL_DEPTH)
    ) u_ram (
      .clk_i       (clk_i),
      .wr_en_i     (wr_lvl[l].en),
      .wr_addr_i   (wr_lvl[l].idx[LAW-1:0]),
      .wr_data_i   (wr_lvl[l].data),
      .rd_addr_a_i (rd_idx_a[l][LAW-1:0]),
      .rd_addr_b_i (rd_idx_b[l][LAW-1:0]),
      .rd_data_a_o (rd_data_a[l]),
      .rd_data_b_o (rd_data_b[l])
    );
  end

  always_comb begin
    fetch_val = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (fetch_vec[k]) begin
        fetch_val = fetch_data[k];
      end
    end
  end

  assign done_any   = |done_vec;
  assign fetch_any  = |fetch_vec;
  assign in_stall_o = (state_q != mhpq_pkg::T_IDLE);
  assign last_node  = fill_q - mhpq_pkg::NODE_W'(1);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    removed_d = removed_q;
    status_d  = status_q;
    start_tok = '0;
    start_lvl = '0;
    direct_wr = '0;
    out_load  = 1'b0;
    unique case (state_q)
      mhpq_pkg::T_IDLE: begin
        if (in_valid_i) begin
          removed_d = '0;
          status_d  = mhpq_pkg::ST_DONE;
          unique case (func_i)
            mhpq_pkg::FN_INSERT: begin
              if (fill_q >= mhpq_pkg::NODE_W'(mhpq_pkg::CAPACITY)) begin
                status_d = mhpq_pkg::ST_FULL;
                state_d  = mhpq_pkg::T_DONE;
              end else if (fill_q == '0) begin
                fill_d         = fill_q + mhpq_pkg::NODE_W'(1);
                direct_wr.en   = 1'b1;
                direct_wr.idx  = '0;
                direct_wr.data = value_i;
                state_d        = mhpq_pkg::T_DONE;
              end else begin
                fill_d          = fill_q + mhpq_pkg::NODE_W'(1);
                start_tok.valid = 1'b1;
                start_tok.kind  = mhpq_pkg::K_UP;
                start_tok.value = value_i;
                start_tok.idx   = mhpq_pkg::node_index(fill_q);
                start_lvl       = mhpq_pkg::node_level(fill_q) - mhpq_pkg::LVL_W'(1);
                state_d         = mhpq_pkg::T_BUSY;
              end
            end
            mhpq_pkg::FN_REMOVE: begin
              if (fill_q == '0) begin
                status_d = mhpq_pkg::ST_EMPTY;
                state_d  = mhpq_pkg::T_DONE;
              end else begin
                removed_d = top_q;
                fill_d    = last_node;
                if (last_node == '0) begin
                  state_d = mhpq_pkg::T_DONE;
                end else begin
                  start_tok.valid = 1'b1;
                  start_tok.kind  = mhpq_pkg::K_FETCH;
                  start_tok.value = '0;
                  start_tok.idx   = mhpq_pkg::node_index(last_node);
                  start_lvl       = mhpq_pkg::node_level(last_node);
                  state_d         = mhpq_pkg::T_FETCH;
                end
              end
            end
          endcase
        end
      end
      mhpq_pkg::T_FETCH: begin
        if (fetch_any) begin
          // last entry becomes the hole value at the root
          start_tok.valid = 1'b1;
          start_tok.kind  = mhpq_pkg::K_DOWN;
          start_tok.value = fetch_val;
          start_tok.idx   = '0;
          start_lvl       = mhpq_pkg::LVL_W'(1);
          state_d         = mhpq_pkg::T_BUSY;
        end
      end
      mhpq_pkg::T_BUSY: begin
        if (done_any) begin
          state_d = mhpq_pkg::T_DONE;
        end
      end
      mhpq_pkg::T_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = mhpq_pkg::T_IDLE;
        end
      end
      default: begin
        state_d = mhpq_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhpq_pkg::T_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    status_q  <= status_d;
    if (wr_lvl[0].en) begin
      top_q <= wr_lvl[0].data;
    end
    if (out_load) begin
      out_removed_q   <= removed_q;
      out_status_q    <= status_q;
      out_count_q     <= mhpq_pkg::COUNT_OUT_W'(fill_q);
      out_top_valid_q <= (fill_q != '0);
      out_top_q       <= (fill_q != '0) ? top_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = out_removed_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = out_count_q;
  assign top_value_o     = out_top_q;
  assign top_valid_o     = out_top_valid_q;

endmodule

>>> sv/mhpq_ram.sv
// generic memory: one write port, two read ports with registered read data
// no dependencies
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_a_i,
  input  logic [AW-1:0]    rd_addr_b_i,
  output logic [WIDTH-1:0] rd_data_a_o,
  output logic [WIDTH-1:0] rd_data_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

>>> sv/mhpq_cell.sv
// one heap level: takes a sift or fetch transaction, reads its level memory,
// compares and hands the transaction or a write to the neighboring level; uses mhpq_pkg
module mhpq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mhpq_pkg::NODE_W-1:0]   level_base_i,
  input  logic                          first_i,
  input  logic                          last_i,
  input  logic [mhpq_pkg::NODE_W-1:0]   fill_i,
  input  mhpq_pkg::tok_t                tok_i,
  output mhpq_pkg::tok_t                tok_up_o,
  output mhpq_pkg::tok_t                tok_dn_o,
  output mhpq_pkg::wr_t                 wr_self_o,
  output mhpq_pkg::wr_t                 wr_above_o,
  output mhpq_pkg::wr_t                 wr_below_o,
  output logic                          done_o,
  output logic                          fetch_valid_o,
  output mhpq_pkg::val_t                fetch_data_o,
  output logic [mhpq_pkg::IDX_W-1:0]    rd_idx_a_o,
  output logic [mhpq_pkg::IDX_W-1:0]    rd_idx_b_o,
  input  mhpq_pkg::val_t                rd_data_a_i,
  input  mhpq_pkg::val_t                rd_data_b_i
);

  mhpq_pkg::cell_state_e            state_q, state_d;
  mhpq_pkg::tok_kind_e              kind_q;
  mhpq_pkg::val_t                   value_q;
  logic [mhpq_pkg::IDX_W-1:0]       idx_q;

  logic [mhpq_pkg::IDX_W-1:0]       child_idx;
  logic [mhpq_pkg::IDX_W-1:0]       parent_idx;
  logic [mhpq_pkg::NODE_W-1:0]      left_node;
  logic [mhpq_pkg::NODE_W-1:0]      right_node;
  logic                             pick_right;
  mhpq_pkg::val_t                   pick_val;
  logic [mhpq_pkg::IDX_W-1:0]       pick_idx;

  assign child_idx  = idx_q << 1;
  assign parent_idx = idx_q >> 1;
  assign left_node  = level_base_i + mhpq_pkg::NODE_W'(child_idx);
  assign right_node = left_node + mhpq_pkg::NODE_W'(1);
  assign pick_right = (right_node < fill_i) && (rd_data_b_i > rd_data_a_i);
  assign pick_val   = pick_right ? rd_data_b_i : rd_data_a_i;
  assign pick_idx   = pick_right ? (child_idx | mhpq_pkg::IDX_W'(1)) : child_idx;

  assign rd_idx_a_o = (kind_q == mhpq_pkg::K_UP)   ? parent_idx :
                      (kind_q == mhpq_pkg::K_DOWN) ? child_idx  : idx_q;
  assign rd_idx_b_o = child_idx | mhpq_pkg::IDX_W'(1);

  always_comb begin
    state_d       = state_q;
    tok_up_o      = '0;
    tok_dn_o      = '0;
    wr_self_o     = '0;
    wr_above_o    = '0;
    wr_below_o    = '0;
    done_o        = 1'b0;
    fetch_valid_o = 1'b0;
    fetch_data_o  = rd_data_a_i;
    unique case (state_q)
      mhpq_pkg::C_IDLE: begin
      end
      mhpq_pkg::C_RD: begin
        if (kind_q == mhpq_pkg::K_DOWN && left_node >= fill_i) begin
          // hole has no children
          wr_above_o.en   = 1'b1;
          wr_above_o.idx  = idx_q;
          wr_above_o.data = value_q;
          done_o          = 1'b1;
          state_d         = mhpq_pkg::C_IDLE;
        end else begin
          state_d = mhpq_pkg::C_CMP;
        end
      end
      mhpq_pkg::C_CMP: begin
        state_d = mhpq_pkg::C_IDLE;
        case (kind_q)
          mhpq_pkg::K_UP: begin
            wr_below_o.en  = 1'b1;
            wr_below_o.idx = idx_q;
            if (value_q > rd_data_a_i) begin
              wr_below_o.data = rd_data_a_i;
              if (first_i) begin
                wr_self_o.en   = 1'b1;
                wr_self_o.idx  = '0;
                wr_self_o.data = value_q;
                done_o         = 1'b1;
              end else begin
                tok_up_o.valid = 1'b1;
                tok_up_o.kind  = mhpq_pkg::K_UP;
                tok_up_o.value = value_q;
                tok_up_o.idx   = parent_idx;
              end
            end else begin
              wr_below_o.data = value_q;
              done_o          = 1'b1;
            end
          end
          mhpq_pkg::K_DOWN: begin
            wr_above_o.en  = 1'b1;
            wr_above_o.idx = idx_q;
            if (pick_val > value_q) begin
              wr_above_o.data = pick_val;
              if (last_i) begin
                wr_self_o.en   = 1'b1;
                wr_self_o.idx  = pick_idx;
                wr_self_o.data = value_q;
                done_o         = 1'b1;
              end else begin
                tok_dn_o.valid = 1'b1;
                tok_dn_o.kind  = mhpq_pkg::K_DOWN;
                tok_dn_o.value = value_q;
                tok_dn_o.idx   = pick_idx;
              end
            end else begin
              wr_above_o.data = value_q;
              done_o          = 1'b1;
            end
          end
          mhpq_pkg::K_FETCH: begin
            fetch_valid_o = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = mhpq_pkg::C_IDLE;
      end
    endcase
    if (tok_i.valid) begin
      state_d = mhpq_pkg::C_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      kind_q  <= tok_i.kind;
      value_q <= tok_i.value;
      idx_q   <= tok_i.idx;
    end
  end

endmodule

>>> sv/mhpq_checker.sv
// port-level checks on the max-heap priority queue, bound to the top level
// uses mhpq_pkg and max_heap_priority_queue_macros.svh
`include "max_heap_priority_queue_macros.svh"

module mhpq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] removed_value_o,
  input logic [1:0]         status_o,
  input logic [6:0]         entry_count_o,
  input logic signed [31:0] top_value_o,
  input logic               top_valid_o
);

  // stalled transaction keeps its payload
  `MHPQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(removed_value_o) && $stable(top_value_o), "stalled result changed")

  `MHPQ_ASSERT(a_full_count, clk_i, rst_ni, out_valid_o && status_o == mhpq_pkg::ST_FULL |-> entry_count_o == 7'(mhpq_pkg::CAPACITY) && top_valid_o, "full reject with wrong count")

  `MHPQ_ASSERT(a_empty_reject, clk_i, rst_ni, out_valid_o && status_o == mhpq_pkg::ST_EMPTY |-> entry_count_o == 7'd0 && !top_valid_o && removed_value_o == 32'sd0, "empty reject not empty")

  `MHPQ_ASSERT(a_top_zero, clk_i, rst_ni, out_valid_o && !top_valid_o |-> top_value_o == 32'sd0, "top value nonzero on empty heap")

  `MHPQ_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o && !in_stall_o, "outputs active in reset")

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

>>> sim/max_heap_priority_queue_test.sv
// self-checking testbench for max_heap_priority_queue: random and directed insert and
// remove transactions, each result checked against a heap model kept in the testbench
// depends on mhpq_pkg and the max_heap_priority_queue rtl
module max_heap_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic           fn;
    mhpq_pkg::val_t value;
  } heap_op_t;

  typedef struct {
    mhpq_pkg::val_t    removed;
    mhpq_pkg::status_e status;
    logic [6:0]        count;
    mhpq_pkg::val_t    top;
    logic              top_ok;
  } heap_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               func_i = mhpq_pkg::FN_INSERT;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] removed_value_o;
  logic [1:0]         status_o;
  logic [6:0]         entry_count_o;
  logic signed [31:0] top_value_o;
  logic               top_valid_o;

  heap_op_t     pending_q[$];
  heap_result_t result_q[$];

  mhpq_pkg::val_t heap_mem [mhpq_pkg::CAPACITY];
  int   heap_fill = 0;

  int   cycle_count = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   fail_count = 0;
  int   n_inserts = 0;
  int   n_removals = 0;
  int   n_full_rejects = 0;
  int   n_empty_rejects = 0;
  int   peak_fill = 0;
  int   hold_left = 0;
  int   hold_mark = 300;
  logic in_fire = 1'b0;
  logic calm;

  assign calm = (n_in >= 400) && (n_in < 600);

  max_heap_priority_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .top_value_o    (top_value_o),
    .top_valid_o    (top_valid_o)
  );

  function automatic heap_result_t heap_apply(input logic fn, input mhpq_pkg::val_t v);
    heap_result_t   r;
    int             pos;
    int             parent;
    int             left;
    int             pick;
    mhpq_pkg::val_t tmp;
    r.removed = '0;
    r.status  = mhpq_pkg::ST_DONE;
    if (fn == mhpq_pkg::FN_INSERT) begin
      if (heap_fill >= mhpq_pkg::CAPACITY) begin
        r.status = mhpq_pkg::ST_FULL;
        n_full_rejects++;
      end else begin
        n_inserts++;
        pos = heap_fill;
        heap_mem[pos] = v;
        heap_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_mem[pos] <= heap_mem[parent]) break;
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[parent];
          heap_mem[parent] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = mhpq_pkg::ST_EMPTY;
        n_empty_rejects++;
      end else begin
        n_removals++;
        r.removed = heap_mem[0];
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        pos = 0;
        while (2 * pos + 1 < heap_fill) begin
          left = 2 * pos + 1;
          pick = left;
          // ties between children go left
          if (left + 1 < heap_fill && heap_mem[left + 1] > heap_mem[left]) pick = left + 1;
          if (heap_mem[pick] <= heap_mem[pos]) break;
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[pick];
          heap_mem[pick] = tmp;
          pos = pick;
        end
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    r.count  = 7'(heap_fill);
    r.top_ok = (heap_fill != 0);
    r.top    = (heap_fill != 0) ? heap_mem[0] : '0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("transaction %0d: %s expected %0d, got %0d", n_out, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic add_op(input logic fn, input mhpq_pkg::val_t v);
    heap_op_t op;
    op.fn    = fn;
    op.value = v;
    pending_q.push_back(op);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    heap_result_t want;
    cycle_count <= cycle_count + 1;
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        result_q.push_back(heap_apply(func_i, value_i));
        n_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("removed_value", want.removed, removed_value_o);
          check_field("status", want.status, status_o);
          check_field("entry_count", want.count, entry_count_o);
          check_field("top_value", want.top, top_value_o);
          check_field("top_valid", want.top_ok, top_valid_o);
        end
        n_out++;
      end
    end
  end

  always @(negedge clk_i) begin
    heap_op_t nxt;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
        nxt = pending_q.pop_front();
        in_valid_i <= 1'b1;
        func_i     <= nxt.fn;
        value_i    <= nxt.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-offs let the block back up into its input
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (n_in >= hold_mark) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_mark   <= hold_mark + 600;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 35);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, result_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int             run_len;
    int             p_ins;
    int             roll;
    int             seg;
    mhpq_pkg::val_t v;

    // empty and single-entry corners, extremes, ties
    add_op(mhpq_pkg::FN_REMOVE, 32'sd7);
    add_op(mhpq_pkg::FN_INSERT, 32'sh8000_0000);
    add_op(mhpq_pkg::FN_REMOVE, '0);
    add_op(mhpq_pkg::FN_REMOVE, '1);
    add_op(mhpq_pkg::FN_INSERT, 32'sd0);
    add_op(mhpq_pkg::FN_INSERT, -32'sd1);
    add_op(mhpq_pkg::FN_INSERT, 32'sh7fff_ffff);
    add_op(mhpq_pkg::FN_INSERT, 32'sh8000_0000);
    add_op(mhpq_pkg::FN_INSERT, 32'sd5);
    add_op(mhpq_pkg::FN_INSERT, 32'sd5);
    add_op(mhpq_pkg::FN_INSERT, -32'sd1);
    repeat (4) add_op(mhpq_pkg::FN_REMOVE, 32'sh5a5a_a5a5);
    add_op(mhpq_pkg::FN_INSERT, 32'sd5);
    repeat (5) add_op(mhpq_pkg::FN_REMOVE, '0);

    seg = 0;
    while (pending_q.size() < ITEM_TARGET) begin
      if (seg == 0) begin
        run_len = 110;
        p_ins   = 95;
      end else if (seg == 1) begin
        run_len = 110;
        p_ins   = 10;
      end else begin
        run_len = $urandom_range(120, 30);
        case ($urandom_range(2))
          0:       p_ins = 90;
          1:       p_ins = 15;
          default: p_ins = 55;
        endcase
      end
      for (int k = 0; k < run_len; k++) begin
        roll = $urandom_range(99);
        if (roll < 60) begin
          v = $urandom;
        end else if (roll < 85) begin
          v = $urandom_range(8) - 4;
        end else begin
          case ($urandom_range(3))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = '0;
            default: v = '1;
          endcase
        end
        add_op(($urandom_range(99) < p_ins) ? mhpq_pkg::FN_INSERT : mhpq_pkg::FN_REMOVE, v);
      end
      seg++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transactions: %0d inserts, %0d removals, %0d rejected full, %0d rejected empty",
             n_in, n_inserts, n_removals, n_full_rejects, n_empty_rejects);
    $display("peak fill %0d of %0d entries, %0d mismatches", peak_fill, mhpq_pkg::CAPACITY,
             fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
